// ===== sv/icf_pkg.sv =====
// ----------------------------------------------------------------------------
// icf_pkg: shared types and constants of the IMU complementary filter
// Holds the register indexes, sequencer states, the CORDIC arctangent table
// and the saturation helper.
// ----------------------------------------------------------------------------
package icf_pkg;

   localparam int ICF_CORDIC_STEPS = 16;
   localparam int ICF_TAB_LEN      = 24;
   localparam int ICF_TAB_IDX_W    = 5;

   localparam int ICF_CSR_IDX_W  = 1;
   localparam int ICF_CSR_DATA_W = 17;

   localparam logic [ICF_CSR_IDX_W-1:0] REG_BLEND_WEIGHT  = 1'b0;
   localparam logic [ICF_CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'b1;

   localparam logic [16:0] BLEND_WEIGHT_RESET = 17'd64225;
   localparam logic [16:0] BLEND_WEIGHT_MAX   = 17'd65536;

   // 1/K of the CORDIC in Q1.30.
   localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
   localparam logic signed [31:0] DEG90_Q16    = 32'sd5898240;

   // The rounded division by 1000 is done as a + floor((3*a + 62) / 125), the
   // last term by multiplying with ceil(2^34 / 125) and keeping bits 34 and up.
   localparam logic [26:0]        DIV_BIAS  = 27'd62;
   localparam logic signed [30:0] RECIP_125 = 31'sd137438954;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CPRE,
      ST_CITER,
      ST_CEND,
      ST_MHI,
      ST_GMUL,
      ST_GDIV,
      ST_GDHI,
      ST_GFIN,
      ST_BLO,
      ST_BHI,
      ST_BFIN,
      ST_DONE
   } icf_state_type;

   // round(atan(2^-i) * 180 / pi * 65536)
   function automatic logic signed [31:0] icf_atan(input logic [ICF_TAB_IDX_W-1:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd2949120;
         5'd1:  v = 32'sd1740967;
         5'd2:  v = 32'sd919879;
         5'd3:  v = 32'sd466945;
         5'd4:  v = 32'sd234379;
         5'd5:  v = 32'sd117304;
         5'd6:  v = 32'sd58666;
         5'd7:  v = 32'sd29335;
         5'd8:  v = 32'sd14668;
         5'd9:  v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] icf_sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/icf_if.sv =====
// ----------------------------------------------------------------------------
// icf_if: channel interfaces of the IMU complementary filter
// One interface carries IMU samples in, the other carries attitude beats out.
// ----------------------------------------------------------------------------
interface icf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [17:0] rate_x;
   logic signed [17:0] rate_y;
   logic signed [17:0] rate_z;

   modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                   output ready);
endinterface

interface icf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pitch_out;
   logic signed [31:0] roll_out;
   logic signed [31:0] yaw_out;

   modport source (output valid, pitch_out, roll_out, yaw_out, input ready);
   modport sink   (input valid, pitch_out, roll_out, yaw_out, output ready);
endinterface

// ===== sv/imu_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_filter: complementary-filter attitude estimator
// Takes one IMU sample per beat and returns updated pitch, roll and yaw.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_if   in         valid/ready            accel_x/y/z (16b), rate_x/y/z (18b)
//   rsp_if   out        valid/ready            pitch_out, roll_out, yaw_out (32b)
//   csr_*    in         write enable only      index (1b), write data (17b)
//
// Each sample runs through two vectoring CORDIC passes on one shared add/shift
// unit, one step per cycle, CORDIC_STEPS steps each (16 by default; more than
// 24 steps are not run), then, per gyro axis, through GMUL, GDIV, GDHI and GFIN
// for the scaled rate and its rounded division by 1000, and through BLO, BHI
// and BFIN for each blend.
// Reset is synchronous: it clears angles, period and sequencer, and resets the weight.
// A new sample is taken while the previous result still waits on rsp_if; the
// block holds a finished result in its last step until the output beat is free.
//
module imu_complementary_filter
   import icf_pkg::*;
#(
   parameter int CORDIC_STEPS = ICF_CORDIC_STEPS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [ICF_CSR_IDX_W-1:0]  csr_index,
   input  logic [ICF_CSR_DATA_W-1:0] csr_wdata,
   icf_req_if.sink                   req_if,
   icf_rsp_if.source                 rsp_if
);

   // The CORDIC table holds 24 angles, so more steps than that are not run.
   localparam int NumIter = (CORDIC_STEPS > ICF_TAB_LEN) ? ICF_TAB_LEN : CORDIC_STEPS;
   localparam logic [ICF_TAB_IDX_W-1:0] LastIter = ICF_TAB_IDX_W'(NumIter - 1);

   icf_state_type state_ff, state_in;

   // Configuration registers.
   logic [16:0] weight_ff, weight_in;
   logic [7:0]  period_ff, period_in;

   // Attitude state; it is also the payload of the output beat.
   logic signed [31:0] pitch_ff, pitch_in;
   logic signed [31:0] roll_ff, roll_in;
   logic signed [31:0] yaw_ff, yaw_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Latched sample and blend weight.
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [17:0] rate_ff [3];
   logic signed [17:0] rate_in [3];
   logic [16:0]        k_ff, k_in;

   // CORDIC unit.
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] cz_ff, cz_in;
   logic [ICF_TAB_IDX_W-1:0] iter_ff, iter_in;
   logic               pass_ff, pass_in;
   logic               zero_ff, zero_in;

   // Product accumulator, accelerometer angles and the divider operand.
   logic signed [67:0] acc_ff, acc_in;
   logic signed [31:0] pacc_ff, pacc_in, racc_ff, racc_in;
   logic [26:0]        div_ff, div_in;
   logic [1:0]         axis_ff, axis_in;
   logic signed [35:0] diff_ff, diff_in;
   logic signed [31:0] new_ff [3];
   logic signed [31:0] new_in [3];

   // Shared multiplier: 19 x 31 bits signed.
   logic signed [18:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [49:0] mul_p;

   assign mul_p = {{31{mul_a[18]}}, mul_a} * {{19{mul_b[30]}}, mul_b};

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pitch_out = pitch_ff;
   assign rsp_if.roll_out  = roll_ff;
   assign rsp_if.yaw_out   = yaw_ff;

   always_comb begin
      logic signed [35:0] px, py, dx, dy, mag, g;
      logic signed [31:0] old_angle, acc_angle, zang;
      logic signed [17:0] r;
      logic [17:0]        r_abs;
      logic [26:0]        q;
      logic signed [27:0] delta;
      logic signed [67:0] sum;

      state_in     = state_ff;
      weight_in    = weight_ff;
      period_in    = period_ff;
      pitch_in     = pitch_ff;
      roll_in      = roll_ff;
      yaw_in       = yaw_ff;
      rsp_valid_in = rsp_valid_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      rate_in      = rate_ff;
      k_in         = k_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      iter_in      = iter_ff;
      pass_in      = pass_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      pacc_in      = pacc_ff;
      racc_in      = racc_ff;
      div_in       = div_ff;
      axis_in      = axis_ff;
      diff_in      = diff_ff;
      new_in       = new_ff;

      r         = rate_ff[axis_ff];
      r_abs     = r[17] ? 18'(-r) : 18'(r);
      zang      = zero_ff ? 32'sd0 : cz_ff;
      mag       = acc_ff[65:30];
      dx        = cx_ff >>> iter_ff;
      dy        = cy_ff >>> iter_ff;
      // The accumulator holds a * 2^34 plus (3*a + 62) * ceil(2^34 / 125).
      q         = acc_ff[60:34];
      delta     = r[17] ? -$signed({1'b0, q}) : $signed({1'b0, q});

      case (axis_ff)
         2'd0:    begin old_angle = pitch_ff; acc_angle = pacc_ff; end
         2'd1:    begin old_angle = roll_ff;  acc_angle = racc_ff; end
         default: begin old_angle = yaw_ff;   acc_angle = racc_ff; end
      endcase
      g   = 36'(old_angle) + 36'(delta);
      sum = ($signed(68'(acc_angle)) <<< 16) + acc_ff + 68'sd32768;

      // The first CORDIC pass works on (z, y), the second on (magnitude, x).
      if (pass_ff) begin
         px = mag;
         py = {{6{ax_ff[15]}}, ax_ff, 14'b0};
      end else begin
         px = {{6{az_ff[15]}}, az_ff, 14'b0};
         py = {{6{ay_ff[15]}}, ay_ff, 14'b0};
      end

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CEND: begin mul_a = {1'b0, cx_ff[17:0]};         mul_b = INV_GAIN_Q30; end
         ST_MHI:  begin mul_a = {cx_ff[35], cx_ff[35:18]};   mul_b = INV_GAIN_Q30; end
         ST_GMUL: begin mul_a = {1'b0, r_abs};               mul_b = {23'b0, period_ff}; end
         ST_GDIV: begin mul_a = {1'b0, div_ff[17:0]};        mul_b = RECIP_125; end
         ST_GDHI: begin mul_a = {10'b0, div_ff[26:18]};      mul_b = RECIP_125; end
         ST_BLO:  begin mul_a = {1'b0, diff_ff[17:0]};       mul_b = {14'b0, k_ff}; end
         ST_BHI:  begin mul_a = {diff_ff[35], diff_ff[35:18]}; mul_b = {14'b0, k_ff}; end
         default: begin mul_a = '0;                          mul_b = '0; end
      endcase

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         case (csr_index)
            REG_BLEND_WEIGHT:  weight_in = csr_wdata;
            REG_SAMPLE_PERIOD: period_in = csr_wdata[7:0];
            default:           weight_in = weight_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               ax_in      = req_if.accel_x;
               ay_in      = req_if.accel_y;
               az_in      = req_if.accel_z;
               rate_in[0] = req_if.rate_x;
               rate_in[1] = req_if.rate_y;
               rate_in[2] = req_if.rate_z;
               k_in       = (weight_ff > BLEND_WEIGHT_MAX) ? BLEND_WEIGHT_MAX : weight_ff;
               pass_in    = 1'b0;
               state_in   = ST_CPRE;
            end
         end
         ST_CPRE: begin
            // Vectors in the left half-plane are turned by a quarter turn first.
            zero_in = (px == 36'sd0) && (py == 36'sd0);
            if (px < 0) begin
               if (py >= 0) begin
                  cx_in = py;  cy_in = -px; cz_in = DEG90_Q16;
               end else begin
                  cx_in = -py; cy_in = px;  cz_in = -DEG90_Q16;
               end
            end else begin
               cx_in = px; cy_in = py; cz_in = 32'sd0;
            end
            iter_in  = '0;
            state_in = ST_CITER;
         end
         ST_CITER: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + dy;
               cy_in = cy_ff - dx;
               cz_in = cz_ff + icf_atan(iter_ff);
            end else begin
               cx_in = cx_ff - dy;
               cy_in = cy_ff + dx;
               cz_in = cz_ff - icf_atan(iter_ff);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LastIter) begin
               state_in = ST_CEND;
            end
         end
         ST_CEND: begin
            if (pass_ff) begin
               racc_in  = -zang;
               axis_in  = 2'd0;
               state_in = ST_GMUL;
            end else begin
               pacc_in  = zang;
               acc_in   = 68'(mul_p);
               state_in = ST_MHI;
            end
         end
         ST_MHI: begin
            acc_in   = acc_ff + ($signed(68'(mul_p)) <<< 18);
            pass_in  = 1'b1;
            state_in = ST_CPRE;
         end
         ST_GMUL: begin
            // a = |rate| * period; 1024*a/1000 rounds to a + floor((3a + 62) / 125).
            div_in   = {1'b0, mul_p[25:0]} + {mul_p[25:0], 1'b0} + DIV_BIAS;
            acc_in   = {8'b0, mul_p[25:0], 34'b0};
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            acc_in   = acc_ff + 68'(mul_p);
            state_in = ST_GDHI;
         end
         ST_GDHI: begin
            acc_in   = acc_ff + ($signed(68'(mul_p)) <<< 18);
            state_in = ST_GFIN;
         end
         ST_GFIN: begin
            if (axis_ff == 2'd2) begin
               new_in[2] = icf_sat32(68'(g));
               state_in  = ST_DONE;
            end else begin
               diff_in  = g - 36'(acc_angle);
               state_in = ST_BLO;
            end
         end
         ST_BLO: begin
            acc_in   = 68'(mul_p);
            state_in = ST_BHI;
         end
         ST_BHI: begin
            acc_in   = acc_ff + ($signed(68'(mul_p)) <<< 18);
            state_in = ST_BFIN;
         end
         ST_BFIN: begin
            new_in[axis_ff] = icf_sat32(sum >>> 16);
            axis_in         = axis_ff + 1'b1;
            state_in        = ST_GMUL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               pitch_in     = new_ff[0];
               roll_in      = new_ff[1];
               yaw_in       = new_ff[2];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         weight_ff    <= BLEND_WEIGHT_RESET;
         period_ff    <= '0;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         period_ff    <= period_in;
         pitch_ff     <= pitch_in;
         roll_ff      <= roll_in;
         yaw_ff       <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      rate_ff <= rate_in;
      k_ff    <= k_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      iter_ff <= iter_in;
      pass_ff <= pass_in;
      zero_ff <= zero_in;
      acc_ff  <= acc_in;
      pacc_ff <= pacc_in;
      racc_ff <= racc_in;
      div_ff  <= div_in;
      axis_ff <= axis_in;
      diff_ff <= diff_in;
      new_ff  <= new_in;
   end

endmodule

// ===== sv/icf_checker.sv =====
// ----------------------------------------------------------------------------
// icf_assertions: port-level checks of the IMU complementary filter
// Watches the handshakes of both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module icf_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pitch,
   input logic [31:0] rsp_roll,
   input logic [31:0] rsp_yaw
);

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pitch) && $stable(rsp_roll) && $stable(rsp_yaw))
      else $error("result payload changed under stall");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A sample occupies the block: no second sample in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while the previous one is in work");

   // A new result cannot appear in the cycle right after a sample is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind imu_complementary_filter icf_assertions u_icf_assertions (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_pitch (rsp_if.pitch_out),
   .rsp_roll  (rsp_if.roll_out),
   .rsp_yaw   (rsp_if.yaw_out)
);

// ===== bench/icf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_checker: attitude predictor and scoreboard for the complementary filter
// Watches the sample and attitude channels and the register port, predicts
// each attitude beat and compares it field by field with the oldest one due.
// ----------------------------------------------------------------------------
module icf_checker
   import icf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [ICF_CSR_IDX_W-1:0]  csr_index,
   input  logic [ICF_CSR_DATA_W-1:0] csr_wdata,
   icf_req_if                        req_if,
   icf_rsp_if                        rsp_if,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic signed [31:0] pitch;
      logic signed [31:0] roll;
      logic signed [31:0] yaw;
   } attitude_type;

   attitude_type attitude_due[$];
   logic [16:0]  weight_k;
   logic [7:0]   period_ms;
   longint       pitch_st, roll_st, yaw_st;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Vectoring CORDIC: returns the angle, gain-corrected magnitude in mag.
   function automatic longint vector_angle(longint x, longint y, output longint mag);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = DEG90_Q16;
         end else begin
            t = x; x = -y; y = t; z = -DEG90_Q16;
         end
      end
      for (int i = 0; i < ICF_CORDIC_STEPS && i < ICF_TAB_LEN; i++) begin
         dx = shr_floor(x, i);
         dy = shr_floor(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; z += longint'(icf_atan(i[4:0]));
         end else begin
            x -= dy; y += dx; z -= longint'(icf_atan(i[4:0]));
         end
      end
      mag = shr_floor(x * longint'(INV_GAIN_Q30), 30);
      return z;
   endfunction

   function automatic longint gyro_step(longint rate, longint per);
      longint n;
      n = rate * per * 1024;
      if (n >= 0) return (n + 500) / 1000;
      return -((-n + 500) / 1000);
   endfunction

   function automatic longint mix(longint g, longint a, longint k);
      return shr_floor(k * g + (65536 - k) * a + 32768, 16);
   endfunction

   assign pending_count = attitude_due.size();

   always @(posedge clock) begin
      longint mag, dummy, p_acc, r_acc, pg, rg, yg, k;
      attitude_type a, got;
      if (reset) begin
         weight_k   <= BLEND_WEIGHT_RESET;
         period_ms  <= 8'd0;
         pitch_st   = 0;
         roll_st    = 0;
         yaw_st     = 0;
         fail_count <= 0;
         attitude_due.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == REG_BLEND_WEIGHT) weight_k <= csr_wdata;
            else if (csr_index == REG_SAMPLE_PERIOD) period_ms <= csr_wdata[7:0];
         end
         if (req_if.valid && req_if.ready) begin
            k = (weight_k > BLEND_WEIGHT_MAX) ? 65536 : longint'(weight_k);
            p_acc = vector_angle(longint'(req_if.accel_z) <<< 14,
                                 longint'(req_if.accel_y) <<< 14, mag);
            r_acc = -vector_angle(mag, longint'(req_if.accel_x) <<< 14, dummy);
            pg = pitch_st + gyro_step(req_if.rate_x, period_ms);
            rg = roll_st + gyro_step(req_if.rate_y, period_ms);
            yg = yaw_st + gyro_step(req_if.rate_z, period_ms);
            pitch_st = clamp32(mix(pg, p_acc, k));
            roll_st  = clamp32(mix(rg, r_acc, k));
            yaw_st   = clamp32(yg);
            a.pitch = pitch_st[31:0];
            a.roll  = roll_st[31:0];
            a.yaw   = yaw_st[31:0];
            attitude_due.push_back(a);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.pitch_out, rsp_if.roll_out, rsp_if.yaw_out};
            if (attitude_due.size() == 0) begin
               $display("%0t: attitude beat with none due: got %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               a = attitude_due.pop_front();
               if (got !== a) begin
                  $display({"%0t: attitude mismatch: expected p=%0d r=%0d y=%0d,",
                            " got p=%0d r=%0d y=%0d"},
                           $time, a.pitch, a.roll, a.yaw, got.pitch, got.roll, got.yaw);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== bench/tb_imu_complementary_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_complementary_filter: testbench top of the complementary filter
// Drives IMU samples and register writes with random gaps on both channels,
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_imu_complementary_filter;
   import icf_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [ICF_CSR_IDX_W-1:0]  csr_index = '0;
   logic [ICF_CSR_DATA_W-1:0] csr_wdata = '0;
   int                        fail_count, pending_count;
   int                        quiet_cycles = 0;

   // A result may also wait out the longest sink stall, so a generous limit of
   // silent cycles is still short of a hang.
   localparam int WATCHDOG_LIMIT = 20000;

   icf_req_if req_if();
   icf_rsp_if rsp_if();

   imu_complementary_filter uut (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_if(req_if), .rsp_if(rsp_if));

   icf_checker checker_i (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_if(req_if), .rsp_if(rsp_if),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap length: none half the time, else mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // The sink side stalls at random, independent of the source.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_if.ready <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end else begin
         rsp_if.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [ICF_CSR_IDX_W-1:0] idx,
                            input logic [ICF_CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every beat due has come out, so that registers can change.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Present one sample and hold it until accepted; gaps go before it. The
   // sample stays on the port until the next call or settle() replaces it.
   task automatic send_sample(input logic signed [15:0] ax, ay, az,
                              input logic signed [17:0] rx, ry, rz);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.accel_x <= ax; req_if.accel_y <= ay; req_if.accel_z <= az;
      req_if.rate_x  <= rx; req_if.rate_y  <= ry; req_if.rate_z  <= rz;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_samples(input int count);
      logic signed [15:0] ax, ay, az;
      logic signed [17:0] rx, ry, rz;
      for (int n = 0; n < count; n++) begin
         // Mostly a plausible gravity vector with small rates; the rest spans
         // the whole range of each field.
         if ($urandom_range(0, 2) != 0) begin
            ax = 16'(int'($urandom_range(0, 8000)) - 4000);
            ay = 16'(int'($urandom_range(0, 8000)) - 4000);
            az = 16'(int'($urandom_range(0, 32000)) - 16000);
            rx = 18'(int'($urandom_range(0, 4000)) - 2000);
            ry = 18'(int'($urandom_range(0, 4000)) - 2000);
            rz = 18'(int'($urandom_range(0, 4000)) - 2000);
         end else begin
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
            rx = 18'($urandom); ry = 18'($urandom); rz = 18'($urandom);
         end
         send_sample(ax, ay, az, rx, ry, rz);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.accel_x = '0; req_if.accel_y = '0; req_if.accel_z = '0;
      req_if.rate_x = '0;  req_if.rate_y = '0;  req_if.rate_z = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples at reset settings: zero vector, pre-rotation by plus
      // and minus ninety degrees, the axis extremes and the straight back case.
      send_sample(16'sd0, 16'sd0, 16'sd0, 18'sd0, 18'sd0, 18'sd0);
      send_sample(16'sd0, 16'sd0, -16'sd32768, 18'sd0, 18'sd0, 18'sd0);
      send_sample(16'sd100, 16'sd500, -16'sd1000, 18'sd5, -18'sd5, 18'sd9);
      send_sample(-16'sd100, -16'sd500, -16'sd1000, 18'sd5, -18'sd5, 18'sd9);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 18'sd131071, 18'sd131071, 18'sd131071);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768,
                  -18'sd131072, -18'sd131072, -18'sd131072);
      send_sample(16'sd0, 16'sd16384, 16'sd0, 18'sd0, 18'sd0, 18'sd0);
      settle();

      // Largest period and full gyro weight: the angles follow the integrated rates alone.
      write_reg(REG_SAMPLE_PERIOD, 17'd255);
      write_reg(REG_BLEND_WEIGHT, BLEND_WEIGHT_MAX);
      for (int n = 0; n < 8; n++)
         send_sample(16'sd1000, 16'sd0, 16'sd16000, 18'sd131071, -18'sd131072, 18'sd131071);
      for (int n = 0; n < 8; n++)
         send_sample(-16'sd1000, 16'sd0, 16'sd16000, -18'sd131072, 18'sd131071, -18'sd131072);
      settle();

      // Weight above the top is clamped; the all-ones value sets every bit.
      write_reg(REG_BLEND_WEIGHT, 17'h1ffff);
      write_reg(REG_SAMPLE_PERIOD, 17'd1);
      random_samples(60);
      settle();

      // Accelerometer only, no integration.
      write_reg(REG_BLEND_WEIGHT, 17'd0);
      write_reg(REG_SAMPLE_PERIOD, 17'd0);
      random_samples(80);
      settle();

      // Several random settings, one phase each.
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_BLEND_WEIGHT, 17'($urandom_range(0, 65536)));
         write_reg(REG_SAMPLE_PERIOD, 17'($urandom_range(0, 255)));
         random_samples(90);
         settle();
      end

      settle();
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
